// File: rtl/pett_pkg.sv
// Package for the periodic event timer table: sizes, operation and status
// codes, and the field types shared by the channel interfaces and the RTL.
// No dependencies.
`timescale 1ns / 1ps

package pett_pkg;

   localparam int SLOTS     = 8;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int USED_W    = $clog2(SLOTS + 2);
   localparam int MAX_FIRES = 8;
   localparam int FIRES_W   = $clog2(MAX_FIRES + 1);
   localparam int IVAL_W    = 16;
   localparam int CSR_AW    = 2;
   localparam int CSR_DW    = 32;

   typedef logic [1:0]        op_type;
   typedef logic [1:0]        status_type;
   typedef logic [2:0]        slot_type;
   typedef logic [IVAL_W-1:0] ival_type;

   localparam op_type OP_REGISTER = 2'd0;
   localparam op_type OP_START    = 2'd1;
   localparam op_type OP_STOP     = 2'd2;
   localparam op_type OP_TICK     = 2'd3;

   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_RANGE  = 2'd1;
   localparam status_type ST_NOMEM  = 2'd2;
   localparam status_type ST_NOINIT = 2'd3;

endpackage

// File: rtl/pett_req_if.sv
// Request channel of the periodic event timer table: valid/ready handshake
// with the operation, interval and slot fields. Depends on pett_pkg.
`timescale 1ns / 1ps

interface pett_req_if;
   import pett_pkg::*;

   logic       valid;
   logic       ready;
   op_type     op;
   ival_type   interval_ticks;
   slot_type   slot_index;

   modport source (output valid, output op, output interval_ticks, output slot_index,
                   input ready);
   modport sink   (input valid, input op, input interval_ticks, input slot_index,
                   output ready);
endinterface

// File: rtl/pett_rsp_if.sv
// Response channel of the periodic event timer table: valid/ready handshake
// with status, slot, fired and last fields. Depends on pett_pkg.
`timescale 1ns / 1ps

interface pett_rsp_if;
   import pett_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   slot_type   slot_out;
   logic       fired;
   logic       last;

   modport source (output valid, output status, output slot_out, output fired,
                   output last, input ready);
   modport sink   (input valid, input status, input slot_out, input fired,
                   input last, output ready);
endinterface

// File: rtl/periodic_event_timer_table_top.sv
// Top level of the periodic event timer table: request and response
// channels, slot memory, tick sequencer and configuration port.
// Depends on pett_pkg, pett_req_if, pett_rsp_if and pett_csr.
`timescale 1ns / 1ps

// Usage
// A request on req carries op (register, start, stop or tick), an interval
// and a slot index. Register, start and stop each give one response on rsp.
// A tick gives one response per slot that expired (up to eight), the final
// one marked by last; a tick with no expiry gives a single response with
// fired low. Register, start and stop pass through the execute state, which
// loads the response once the output register is free, and then return to
// idle. While the tick source runs, a tick visits each registered slot in
// turn: an enabled slot gets a memory read, then a check and write-back, a
// disabled one is skipped. One request is handled at a time; req.ready is
// high while the sequencer is idle, even while a response still waits in
// the output register. When the receiver stalls, the sequencer holds at the
// next response it must emit and resumes as soon as the output register is
// taken. The user must write the timer_ready register over the APB port
// only while idle; the block does not enforce it. Synchronous reset empties
// the table, clears every enable bit, halts the tick source and clears
// timer_ready; the slot memory needs no clearing.

module periodic_event_timer_table_top (
   input  logic                         clock,
   input  logic                         reset,
   pett_req_if.sink                     req,
   pett_rsp_if.source                   rsp,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [pett_pkg::CSR_AW-1:0]  paddr,
   input  logic [pett_pkg::CSR_DW-1:0]  pwdata,
   output logic [pett_pkg::CSR_DW-1:0]  prdata,
   output logic                         pready
);
   import pett_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   localparam int MEM_W = 2 * IVAL_W;

   logic                 timer_ready;

   logic [2:0]           state_ff, state_in;
   op_type               op_ff, op_in;
   ival_type             interval_ff, interval_in;
   slot_type             slot_ff, slot_in;
   logic [USED_W-1:0]    idx_ff, idx_in;
   logic [FIRES_W-1:0]   fires_ff, fires_in;
   logic                 pend_v_ff, pend_v_in;
   logic [SLOT_W-1:0]    pend_slot_ff, pend_slot_in;
   logic [SLOTS-1:0]     enable_ff, enable_in;
   logic [USED_W-1:0]    used_ff, used_in;
   logic                 running_ff, running_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   slot_type             rsp_slot_ff, rsp_slot_in;
   logic                 rsp_fired_ff, rsp_fired_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [MEM_W-1:0]     slot_mem [SLOTS];
   logic [MEM_W-1:0]     rd_data_ff;
   logic                 mem_we;
   logic [SLOT_W-1:0]    mem_waddr;
   logic [MEM_W-1:0]     mem_wdata;
   logic                 mem_re;
   logic [SLOT_W-1:0]    mem_raddr;

   logic                 out_free;
   logic [USED_W-1:0]    limit;
   logic [SLOTS-1:0]     slot_bit;
   logic                 slot_ok;
   ival_type             cnt_inc;
   logic                 hit;
   logic                 report;

   pett_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .timer_ready (timer_ready)
   );

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign limit    = (used_ff >= USED_W'(SLOTS)) ? USED_W'(SLOTS) : used_ff;
   assign slot_ok  = USED_W'(slot_ff) < USED_W'(SLOTS);
   assign slot_bit = SLOTS'(1) << slot_ff;

   // Memory word holds the period in the upper half and the counter below.
   assign cnt_inc = rd_data_ff[IVAL_W-1:0] + IVAL_W'(1);
   assign hit     = cnt_inc >= rd_data_ff[MEM_W-1:IVAL_W];
   assign report  = hit && (fires_ff < FIRES_W'(MAX_FIRES));

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      interval_in   = interval_ff;
      slot_in       = slot_ff;
      idx_in        = idx_ff;
      fires_in      = fires_ff;
      pend_v_in     = pend_v_ff;
      pend_slot_in  = pend_slot_ff;
      enable_in     = enable_ff;
      used_in       = used_ff;
      running_in    = running_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_fired_in  = rsp_fired_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff[SLOT_W-1:0];
      mem_wdata     = {rd_data_ff[MEM_W-1:IVAL_W], IVAL_W'(0)};
      mem_re        = 1'b0;
      mem_raddr     = idx_ff[SLOT_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in       = req.op;
               interval_in = req.interval_ticks;
               slot_in     = req.slot_index;
               idx_in      = '0;
               fires_in    = '0;
               pend_v_in   = 1'b0;
               if (req.op != OP_TICK) begin
                  state_in = S_EXEC;
               end else if (running_ff) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end

         S_EXEC: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_slot_in   = '0;
               rsp_fired_in  = 1'b0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
               if (op_ff == OP_REGISTER) begin
                  if (interval_ff == '0) begin
                     rsp_status_in = ST_RANGE;
                  end else if (used_ff >= USED_W'(SLOTS)) begin
                     rsp_status_in = ST_NOMEM;
                     used_in       = USED_W'(SLOTS + 1);
                  end else begin
                     mem_we      = 1'b1;
                     mem_waddr   = used_ff[SLOT_W-1:0];
                     mem_wdata   = {interval_ff, IVAL_W'(0)};
                     rsp_slot_in = slot_type'(used_ff[SLOT_W-1:0]);
                     used_in     = used_ff + USED_W'(1);
                  end
               end else if (!timer_ready) begin
                  rsp_status_in = ST_NOINIT;
               end else if (op_ff == OP_START) begin
                  if (slot_ok) begin
                     enable_in = enable_ff | slot_bit;
                  end
                  running_in = 1'b1;
               end else begin
                  if (slot_ok) begin
                     enable_in = enable_ff & ~slot_bit;
                  end
                  if (enable_in == '0) begin
                     running_in = 1'b0;
                  end
               end
            end
         end

         S_READ: begin
            if (idx_ff >= limit) begin
               state_in = S_FINISH;
            end else if (enable_ff[idx_ff[SLOT_W-1:0]]) begin
               mem_re   = 1'b1;
               state_in = S_CHECK;
            end else begin
               idx_in = idx_ff + USED_W'(1);
            end
         end

         S_CHECK: begin
            // A held expiry is only pushed out once a newer one is known,
            // so that the final response of the tick can carry last.
            if (!(report && pend_v_ff && !out_free)) begin
               mem_we    = 1'b1;
               mem_wdata = {rd_data_ff[MEM_W-1:IVAL_W], hit ? IVAL_W'(0) : cnt_inc};
               if (report) begin
                  if (pend_v_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_slot_in   = slot_type'(pend_slot_ff);
                     rsp_fired_in  = 1'b1;
                     rsp_last_in   = 1'b0;
                  end
                  pend_v_in    = 1'b1;
                  pend_slot_in = idx_ff[SLOT_W-1:0];
                  fires_in     = fires_ff + FIRES_W'(1);
               end
               idx_in   = idx_ff + USED_W'(1);
               state_in = S_READ;
            end
         end

         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_slot_in   = pend_v_ff ? slot_type'(pend_slot_ff) : '0;
               rsp_fired_in  = pend_v_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         enable_ff    <= '0;
         used_ff      <= '0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_v_ff    <= 1'b0;
         fires_ff     <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         used_ff      <= used_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_v_ff    <= pend_v_in;
         fires_ff     <= fires_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      interval_ff   <= interval_in;
      slot_ff       <= slot_in;
      pend_slot_ff  <= pend_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Slot memory: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= slot_mem[mem_raddr];
      end
   end

   assign req.ready    = (state_ff == S_IDLE);
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.status   = rsp_status_ff;
   assign rsp.slot_out = rsp_slot_ff;
   assign rsp.fired    = rsp_fired_ff;
   assign rsp.last     = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(SLOTS + 1))
      else $error("slot count beyond saturation value");

   a_enable_runs: assert property (@(posedge clock) disable iff (reset)
      enable_ff != '0 |-> running_ff)
      else $error("enabled slot while tick source halted");

   a_fire_bound: assert property (@(posedge clock) disable iff (reset)
      fires_ff <= FIRES_W'(MAX_FIRES))
      else $error("too many expiries recorded for one tick");

   a_check_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHECK && $past(state_ff) != S_CHECK |-> $past(state_ff) == S_READ)
      else $error("check state entered without a memory read");

   a_fired_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_fired_ff |-> rsp_status_ff == ST_OK)
      else $error("fired response with an error status");
`endif

endmodule

// File: rtl/pett_csr.sv
// APB-style configuration register block holding the timer_ready bit.
// Depends on pett_pkg.
`timescale 1ns / 1ps

module pett_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [pett_pkg::CSR_AW-1:0]  paddr,
   input  logic [pett_pkg::CSR_DW-1:0]  pwdata,
   output logic [pett_pkg::CSR_DW-1:0]  prdata,
   output logic                         pready,
   output logic                         timer_ready
);
   import pett_pkg::*;

   logic timer_ready_ff;
   logic timer_ready_in;
   logic wr_en;

   // The single register sits at byte address zero.
   assign wr_en = psel && penable && pwrite && (paddr == '0);

   always_comb begin
      timer_ready_in = timer_ready_ff;
      if (wr_en) begin
         timer_ready_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ready_ff <= 1'b0;
      end else begin
         timer_ready_ff <= timer_ready_in;
      end
   end

   assign pready      = 1'b1;
   assign prdata      = (paddr == '0) ? {{(CSR_DW-1){1'b0}}, timer_ready_ff} : '0;
   assign timer_ready = timer_ready_ff;

endmodule
